>>> hw/rtl/dlmv_pkg.sv
package dlmv_pkg;

    // Array sizes and number format
    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int N_CELLS     = MAX_OUTPUTS;
    localparam int FRAC_BITS   = 12;
    localparam int DATA_W      = 16;
    localparam int LEN_W       = 7;
    localparam int COL_W       = $clog2(MAX_INPUTS);
    localparam int ROW_W       = $clog2(MAX_OUTPUTS);
    localparam int CNT_W       = ROW_W + 1;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = PROD_W + COL_W + 1;
    localparam int SH_W        = ACC_W - FRAC_BITS;

    // Saturation rails of the shifted sum
    localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SH_MIN = SH_W'(-32768);
    localparam logic [DATA_W-1:0] OUT_MAX = 16'h7fff;
    localparam logic [DATA_W-1:0] OUT_MIN = 16'h8000;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_INPUT  = 2'd2
    } op_t;

    typedef enum logic {
        REG_INPUT_LENGTH  = 1'b0,
        REG_OUTPUT_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_FINAL,
        S_UNLOAD
    } state_t;

    // Table write broadcast to every cell
    typedef struct packed {
        logic              wt_we;
        logic              bias_we;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } wr_t;

    // Input element travelling down the chain
    typedef struct packed {
        logic              vld;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] x;
    } beat_t;

    // Per-cycle commands common to all cells
    typedef struct packed {
        logic finalize;
        logic shift;
    } cell_ctl_t;

    // Finished row result, shifted toward cell 0 for unloading
    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } res_t;

endpackage

>>> hw/rtl/dense_layer_matvec_bias.sv
// Dense layer out = W*x + b in signed Q4.12. Load transactions write one weight
// (opcode 0) or one bias (opcode 1); input-element
// transactions (opcode 2) fill the input vector, and the element marked last
// starts a run. A run streams the input elements, one per cycle, down a chain
// of 64 cells, one per output row; each cell keeps its row of weights, its
// bias and a 39-bit accumulator fed by its own 16x16 multiplier. Rows are
// finished with the bias added, a floor shift by 12 and saturation to 16 bits,
// then shifted out of the chain one row per accepted transaction, row 0 first.
// With M = clamped output_length, a run holds in_stall high through its
// compute and through its M output transactions; the unload port gives one
// row per cycle while out_stall is low.
// Stores need no clearing after reset if every entry is written before use;
// the user must ensure this, as the block does not enforce it.
module dense_layer_matvec_bias (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [dlmv_pkg::LEN_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [dlmv_pkg::ROW_W-1:0]  row_index,
    input  logic [dlmv_pkg::COL_W-1:0]  col_index,
    input  logic signed [dlmv_pkg::DATA_W-1:0] value,
    input  logic                        last_element,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dlmv_pkg::ROW_W-1:0]  out_index,
    output logic signed [dlmv_pkg::DATA_W-1:0] out_value,
    output logic                        saturated,
    output logic                        last_of_run
);
    import dlmv_pkg::*;

    wr_t       wr;
    cell_ctl_t ctl;
    beat_t     beat_w [N_CELLS];
    res_t      res_w  [N_CELLS+1];

    // Sequencer, length registers and input buffer
    dlmv_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_index    (out_index),
        .last_of_run  (last_of_run),
        .wr           (wr),
        .beat_o       (beat_w[0]),
        .ctl          (ctl)
    );

    // Nothing shifts in behind the last row
    assign res_w[N_CELLS] = '0;

    // Chain of row cells
    for (genvar g = 0; g < N_CELLS; g++)
    begin : g_cell
        if (g < N_CELLS - 1)
        begin : g_mid
            dlmv_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .row_id (ROW_W'(g)),
                .wr     (wr),
                .ctl    (ctl),
                .beat_i (beat_w[g]),
                .beat_o (beat_w[g+1]),
                .res_i  (res_w[g+1]),
                .res_o  (res_w[g])
            );
        end
        else
        begin : g_end
            dlmv_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .row_id (ROW_W'(g)),
                .wr     (wr),
                .ctl    (ctl),
                .beat_i (beat_w[g]),
                .beat_o (),
                .res_i  (res_w[g+1]),
                .res_o  (res_w[g])
            );
        end
    end

    assign out_value = $signed(res_w[0].value);
    assign saturated = res_w[0].sat;

endmodule

>>> hw/rtl/dlmv_cell.sv
module dlmv_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [dlmv_pkg::ROW_W-1:0] row_id,
    input  dlmv_pkg::wr_t           wr,
    input  dlmv_pkg::cell_ctl_t     ctl,
    input  dlmv_pkg::beat_t         beat_i,
    output dlmv_pkg::beat_t         beat_o,
    input  dlmv_pkg::res_t          res_i,
    output dlmv_pkg::res_t          res_o
);
    import dlmv_pkg::*;

    logic [DATA_W-1:0]        wmem [MAX_INPUTS];
    logic [DATA_W-1:0]        bias_reg;
    logic [DATA_W-1:0]        w_reg;
    logic [DATA_W-1:0]        x_a_reg;
    logic                     vld_a_reg;
    logic                     first_a_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     vld_b_reg;
    logic                     first_b_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    beat_t                    beat_reg;
    res_t                     res_reg;
    logic signed [ACC_W-1:0]  bias_ext;
    logic signed [ACC_W-1:0]  total;
    logic signed [SH_W-1:0]   shifted;
    logic                     sat_hi;
    logic                     sat_lo;
    res_t                     res_next;

    // Row weights: write on a matching load, read at the passing column
    always_ff @(posedge clk)
    begin
        if (wr.wt_we && (wr.row == row_id))
        begin
            wmem[wr.col] <= wr.value;
        end
        w_reg   <= wmem[beat_i.col];
        x_a_reg <= beat_i.x;
    end

    // Hold this row's bias
    always_ff @(posedge clk)
    begin
        if (wr.bias_we && (wr.row == row_id))
        begin
            bias_reg <= wr.value;
        end
    end

    // Pass the element on and track beat validity through the MAC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg    <= '0;
            vld_a_reg   <= 1'b0;
            first_a_reg <= 1'b0;
            vld_b_reg   <= 1'b0;
            first_b_reg <= 1'b0;
        end
        else
        begin
            beat_reg    <= beat_i;
            vld_a_reg   <= beat_i.vld;
            first_a_reg <= (beat_i.col == '0);
            vld_b_reg   <= vld_a_reg;
            first_b_reg <= first_a_reg;
        end
    end

    // Multiply, then accumulate; column zero restarts the sum
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(w_reg) * $signed(x_a_reg);
        if (vld_b_reg)
        begin
            if (first_b_reg)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Add scaled bias, floor shift, saturate
    always_comb
    begin
        bias_ext = ACC_W'($signed(bias_reg)) <<< FRAC_BITS;
        total    = acc_reg + bias_ext;
        shifted  = $signed(total[ACC_W-1:FRAC_BITS]);
        sat_hi   = (shifted > SH_MAX);
        sat_lo   = (shifted < SH_MIN);
        res_next.sat = sat_hi || sat_lo;
        if (sat_hi)
        begin
            res_next.value = OUT_MAX;
        end
        else if (sat_lo)
        begin
            res_next.value = OUT_MIN;
        end
        else
        begin
            res_next.value = shifted[DATA_W-1:0];
        end
    end

    // Capture the result, or take the neighbor's during unload
    always_ff @(posedge clk)
    begin
        if (ctl.finalize)
        begin
            res_reg <= res_next;
        end
        else if (ctl.shift)
        begin
            res_reg <= res_i;
        end
    end

    assign beat_o = beat_reg;
    assign res_o  = res_reg;

endmodule

>>> hw/rtl/dlmv_ctrl.sv
module dlmv_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [dlmv_pkg::LEN_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [dlmv_pkg::ROW_W-1:0]  row_index,
    input  logic [dlmv_pkg::COL_W-1:0]  col_index,
    input  logic [dlmv_pkg::DATA_W-1:0] value,
    input  logic                        last_element,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dlmv_pkg::ROW_W-1:0]  out_index,
    output logic                        last_of_run,
    output dlmv_pkg::wr_t               wr,
    output dlmv_pkg::beat_t             beat_o,
    output dlmv_pkg::cell_ctl_t         ctl
);
    import dlmv_pkg::*;

    logic [DATA_W-1:0] xbuf [MAX_INPUTS];
    logic [LEN_W-1:0]  in_len_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [COL_W-1:0]  nin_m1;
    logic [ROW_W-1:0]  nout_m1;
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              in_acc;
    logic              start;
    logic              feeding;
    logic              x_vld_reg;
    logic [COL_W-1:0]  x_col_reg;
    logic [DATA_W-1:0] x_rd_reg;

    // Length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg  <= LEN_W'(MAX_INPUTS);
            out_len_reg <= LEN_W'(MAX_OUTPUTS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_LENGTH:  in_len_reg  <= cfg_data;
                REG_OUTPUT_LENGTH: out_len_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clamp lengths and take the last index used
    always_comb
    begin
        if (in_len_reg == '0)
        begin
            nin_m1 = '0;
        end
        else if (in_len_reg > LEN_W'(MAX_INPUTS))
        begin
            nin_m1 = COL_W'(MAX_INPUTS - 1);
        end
        else
        begin
            nin_m1 = COL_W'(in_len_reg - LEN_W'(1));
        end

        if (out_len_reg == '0)
        begin
            nout_m1 = '0;
        end
        else if (out_len_reg > LEN_W'(MAX_OUTPUTS))
        begin
            nout_m1 = ROW_W'(MAX_OUTPUTS - 1);
        end
        else
        begin
            nout_m1 = ROW_W'(out_len_reg - LEN_W'(1));
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Decode the accepted transaction
    always_comb
    begin
        wr.wt_we   = 1'b0;
        wr.bias_we = 1'b0;
        wr.row     = row_index;
        wr.col     = col_index;
        wr.value   = value;
        start      = 1'b0;
        case (opcode)
            OP_WEIGHT: wr.wt_we   = in_acc;
            OP_BIAS:   wr.bias_we = in_acc;
            OP_INPUT:  start      = in_acc && last_element;
            default:   ;
        endcase
    end

    // Input vector buffer
    always_ff @(posedge clk)
    begin
        if (in_acc && (opcode == OP_INPUT))
        begin
            xbuf[col_index] <= value;
        end
        x_rd_reg <= xbuf[cnt_reg[COL_W-1:0]];
    end

    // Tag of the element read this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg <= 1'b0;
            x_col_reg <= '0;
        end
        else
        begin
            x_vld_reg <= feeding;
            x_col_reg <= cnt_reg[COL_W-1:0];
        end
    end

    assign beat_o.vld = x_vld_reg;
    assign beat_o.col = x_col_reg;
    assign beat_o.x   = x_rd_reg;

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Feed columns, drain the chain, finalize, unload rows
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        feeding      = 1'b0;
        ctl.finalize = 1'b0;
        ctl.shift    = 1'b0;
        out_valid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    state_next = S_FEED;
                end
            end
            S_FEED:
            begin
                feeding = 1'b1;
                if (cnt_reg[COL_W-1:0] == nin_m1)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == CNT_W'(nout_m1) + CNT_W'(2))
                begin
                    cnt_next   = '0;
                    state_next = S_FINAL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_FINAL:
            begin
                ctl.finalize = 1'b1;
                cnt_next     = '0;
                state_next   = S_UNLOAD;
            end
            S_UNLOAD:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    ctl.shift = 1'b1;
                    if (cnt_reg[ROW_W-1:0] == nout_m1)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    assign out_index   = cnt_reg[ROW_W-1:0];
    assign last_of_run = (cnt_reg[ROW_W-1:0] == nout_m1);

endmodule

>>> hw/rtl/dlmv_checker.sv
module dlmv_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [dlmv_pkg::ROW_W-1:0]  out_index,
    input logic signed [dlmv_pkg::DATA_W-1:0] out_value,
    input logic                        saturated,
    input logic                        last_of_run
);
    import dlmv_pkg::*;

    // No new transaction is taken while rows are unloading
    a_busy_unload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during unload");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_index)
            && $stable(out_value) && $stable(saturated) && $stable(last_of_run))
        else $error("stalled result changed");

    // Rows come out in order within a run
    a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run
            |=> out_valid && (out_index == $past(out_index) + ROW_W'(1)))
        else $error("row sequence broken");

    // Every run starts at row zero
    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_index == '0))
        else $error("run did not start at row zero");

    // A clipped result sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (out_value == $signed(OUT_MAX))
            || (out_value == $signed(OUT_MIN)))
        else $error("saturated result off the rails");

endmodule

bind dense_layer_matvec_bias dlmv_checker u_dlmv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_index   (out_index),
    .out_value   (out_value),
    .saturated   (saturated),
    .last_of_run (last_of_run)
);
